### design/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersector
// Request and result beat layouts, time widths and face normal codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  // Magnitude width of a slab distance (the largest is below 2^34).
  localparam int MAG_W  = 34;
  // Signed width of a slab time, wide enough for the infinite marker.
  localparam int TIME_W = 64;

  localparam logic signed [TIME_W-1:0] T_INF = 64'sh4000_0000_0000_0000;

  // Face normal codes.
  localparam logic [2:0] NRM_NONE = 3'd0;
  localparam logic [2:0] NRM_POSX = 3'd1;
  localparam logic [2:0] NRM_NEGX = 3'd2;
  localparam logic [2:0] NRM_POSY = 3'd3;
  localparam logic [2:0] NRM_NEGY = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic        [30:0] box_width;
    logic        [30:0] box_height;
    logic        [30:0] mover_width;
    logic        [30:0] mover_height;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] entry_time;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic        [2:0]  normal_code;
  } res_t;

  // Saturate a wide signed value into 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined unsigned restoring divider
// One quotient bit per register stage; a new dividend may enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_div #(
  parameter int NW = 50
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [31:0]   divisor_i,
  output logic      [NW-1:0] quotient_o
);

  // Per stage: partial remainder, shifting dividend/quotient word, divisor.
  logic [31:0]   rem_q [NW+1];
  logic [NW-1:0] wrk_q [NW+1];
  logic [31:0]   dvs_q [NW+1];

  // Input capture stage.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    wrk_q[0] <= dividend_i;
    dvs_q[0] <= divisor_i;
  end

  // One restoring step in each stage.
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    always_comb begin
      trial = {rem_q[i], wrk_q[i][NW-1]};
      diff  = trial - {1'b0, dvs_q[i]};
      qbit  = (trial >= {1'b0, dvs_q[i]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= qbit ? diff[31:0] : trial[31:0];
      wrk_q[i+1] <= {wrk_q[i][NW-2:0], qbit};
      dvs_q[i+1] <= dvs_q[i];
    end
  end

  assign quotient_o = wrk_q[NW];

endmodule

`default_nettype wire

### design/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: 2D ray or swept box against an axis-aligned box
// Slab method in fixed point with four pipelined dividers and a compare tail.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Direction  Beat
//  request   start_i, busy_o, req_i     in         one ray or sweep query
//  result    res_valid_o, res_o         out        one hit record per query
//
//  A request beat is taken at every edge with start_i high; busy_o stays low.
//  Each result passes the one-bit-per-stage dividers and the tail stages and
//  appears in request order, for one cycle.
//  Reset clears only the valid bits of the stages; data registers are free.
//  The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire rbsi_pkg::req_t req_i,
  output logic               res_valid_o,
  output rbsi_pkg::res_t     res_o
);

  import rbsi_pkg::*;

  localparam int NW   = MAG_W + FRAC_BITS;
  localparam int DLAT = NW + 1;
  localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(1) << FRAC_BITS;

  // Side information that travels alongside the dividers.
  typedef struct packed {
    logic               swept;
    logic               rej;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic [3:0]         qneg;
    logic [3:0]         inf;
    logic [3:0]         npos;
  } sb_t;

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Front end: slab distances, signs and special cases.
  // --------------------------------------------------------------------------
  logic               swept;
  logic signed [34:0] ox, oy, bl, bt, mw, mh, bw, bh;
  logic signed [34:0] num [4];
  logic signed [31:0] dvs [4];
  logic [NW-1:0]      dvd_mag [4];
  logic [31:0]        dvs_mag [4];
  logic [NW-1:0]      quo [4];
  sb_t                sb_in;

  always_comb begin
    swept = req_i.req_type;
    ox = {{3{req_i.origin_x[31]}}, req_i.origin_x};
    oy = {{3{req_i.origin_y[31]}}, req_i.origin_y};
    bl = {{3{req_i.box_left[31]}}, req_i.box_left};
    bt = {{3{req_i.box_top[31]}}, req_i.box_top};
    bw = {4'b0, req_i.box_width};
    bh = {4'b0, req_i.box_height};
    mw = swept ? {4'b0, req_i.mover_width}  : '0;
    mh = swept ? {4'b0, req_i.mover_height} : '0;

    num[0] = bl - ox - mw;
    num[1] = bt - oy - mh;
    num[2] = bl + bw - ox;
    num[3] = bt + bh - oy;
    dvs[0] = req_i.dir_x;
    dvs[1] = req_i.dir_y;
    dvs[2] = req_i.dir_x;
    dvs[3] = req_i.dir_y;

    sb_in.swept = swept;
    sb_in.dx    = req_i.dir_x;
    sb_in.dy    = req_i.dir_y;
    sb_in.sx    = {ox[32:0]} + (swept ? {3'b0, req_i.mover_width[30:1]}  : 33'sd0);
    sb_in.sy    = {oy[32:0]} + (swept ? {3'b0, req_i.mover_height[30:1]} : 33'sd0);
    sb_in.rej   = swept && (req_i.dir_x == '0) && (req_i.dir_y == '0);

    for (int k = 0; k < 4; k++) begin
      logic signed [34:0] nneg;
      logic signed [31:0] dneg;
      nneg = -num[k];
      dneg = -dvs[k];
      dvd_mag[k] = {(num[k][34] ? nneg[MAG_W-1:0] : num[k][MAG_W-1:0]),
                    {FRAC_BITS{1'b0}}};
      dvs_mag[k] = dvs[k][31] ? dneg : dvs[k];
      sb_in.qneg[k] = num[k][34] ^ dvs[k][31];
      sb_in.inf[k]  = (dvs[k] == '0);
      sb_in.npos[k] = !num[k][34];
      if ((dvs[k] == '0) && (num[k] == '0)) begin
        sb_in.rej = 1'b1;
      end
    end
  end

  // Four dividers: near x, near y, far x, far y.
  for (genvar k = 0; k < 4; k++) begin : g_div
    rbsi_div #(.NW(NW)) u_div (
      .clk_i      (clk_i),
      .dividend_i (dvd_mag[k]),
      .divisor_i  (dvs_mag[k]),
      .quotient_o (quo[k])
    );
  end

  // Side-band delay line matching the divider latency.
  sb_t  sb_q  [DLAT];
  logic vld_q [DLAT];

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_in;
    for (int i = 1; i < DLAT; i++) begin
      sb_q[i] <= sb_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i;
      for (int i = 1; i < DLAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  sb_t sb_d;
  assign sb_d = sb_q[DLAT-1];

  // --------------------------------------------------------------------------
  // Tail stages.
  // --------------------------------------------------------------------------
  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], vld_q[DLAT-1]};
    end
  end

  // Stage 1: signed slab times, with infinite marker for a zero direction.
  logic signed [TIME_W-1:0] t1_q [4];
  sb_t                      sb1_q;

  always_ff @(posedge clk_i) begin
    sb1_q <= sb_d;
    for (int k = 0; k < 4; k++) begin
      if (sb_d.inf[k]) begin
        t1_q[k] <= sb_d.npos[k] ? T_INF : -T_INF;
      end else if (sb_d.qneg[k]) begin
        t1_q[k] <= -$signed(TIME_W'(quo[k]));
      end else begin
        t1_q[k] <= $signed(TIME_W'(quo[k]));
      end
    end
  end

  // Stage 2: order near and far per axis.
  logic signed [TIME_W-1:0] nx2_q, ny2_q, fx2_q, fy2_q;
  sb_t                      sb2_q;

  always_ff @(posedge clk_i) begin
    sb2_q <= sb1_q;
    nx2_q <= (t1_q[0] > t1_q[2]) ? t1_q[2] : t1_q[0];
    fx2_q <= (t1_q[0] > t1_q[2]) ? t1_q[0] : t1_q[2];
    ny2_q <= (t1_q[1] > t1_q[3]) ? t1_q[3] : t1_q[1];
    fy2_q <= (t1_q[1] > t1_q[3]) ? t1_q[1] : t1_q[3];
  end

  // Stage 3: disjoint test, entry and exit times, axis order.
  logic signed [TIME_W-1:0] tn3_q, tf3_q;
  logic                     dis3_q, xgt3_q, xlt3_q;
  sb_t                      sb3_q;

  always_ff @(posedge clk_i) begin
    sb3_q  <= sb2_q;
    dis3_q <= (nx2_q > fy2_q) || (ny2_q > fx2_q);
    tn3_q  <= (nx2_q > ny2_q) ? nx2_q : ny2_q;
    tf3_q  <= (fx2_q < fy2_q) ? fx2_q : fy2_q;
    xgt3_q <= (nx2_q > ny2_q);
    xlt3_q <= (nx2_q < ny2_q);
  end

  // Stage 4: hit decision, clamped entry time and face normal.
  logic               hit4_q;
  logic signed [31:0] ent4_q;
  logic [2:0]         nrm4_q;
  sb_t                sb4_q;

  always_ff @(posedge clk_i) begin
    sb4_q  <= sb3_q;
    hit4_q <= !(sb3_q.rej || dis3_q || tf3_q[TIME_W-1] ||
                (sb3_q.swept && (tn3_q[TIME_W-1] || tn3_q >= T_ONE)));
    ent4_q <= sat32({{2{tn3_q[TIME_W-1]}}, tn3_q});
    if (xgt3_q) begin
      nrm4_q <= sb3_q.dx[31] ? NRM_POSX : NRM_NEGX;
    end else if (xlt3_q) begin
      nrm4_q <= sb3_q.dy[31] ? NRM_POSY : NRM_NEGY;
    end else begin
      nrm4_q <= NRM_NONE;
    end
  end

  // Stage 5: travel products.
  logic signed [63:0] px5_q, py5_q;
  logic               hit5_q;
  logic signed [31:0] ent5_q;
  logic [2:0]         nrm5_q;
  logic signed [32:0] sx5_q, sy5_q;

  always_ff @(posedge clk_i) begin
    px5_q  <= ent4_q * sb4_q.dx;
    py5_q  <= ent4_q * sb4_q.dy;
    hit5_q <= hit4_q;
    ent5_q <= ent4_q;
    nrm5_q <= nrm4_q;
    sx5_q  <= sb4_q.sx;
    sy5_q  <= sb4_q.sy;
  end

  // Stage 6: contact point with floor scaling, result register.
  logic signed [63:0] fx6, fy6;
  res_t               res_q;

  always_comb begin
    fx6 = px5_q >>> FRAC_BITS;
    fy6 = py5_q >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (hit5_q) begin
      res_q.hit         <= 1'b1;
      res_q.entry_time  <= ent5_q;
      res_q.contact_x   <= sat32({{33{sx5_q[32]}}, sx5_q} + {{2{fx6[63]}}, fx6});
      res_q.contact_y   <= sat32({{33{sy5_q[32]}}, sy5_q} + {{2{fy6[63]}}, fy6});
      res_q.normal_code <= nrm5_q;
    end else begin
      res_q <= '0;
    end
  end

  assign res_valid_o = v_q[5];
  assign res_o       = res_q;

endmodule

`default_nettype wire
